// ----- sv/bfq_pkg.sv -----
// Shared constants, command codes and state type of the bloom filter block.
`timescale 1ns / 1ps

package bfq_pkg;

  // Filter geometry: 2^INDEX_BITS bits, NUM_SUBHASHES probes per hash
  localparam int INDEX_BITS    = 14;
  localparam int NUM_SUBHASHES = 5;

  // Store rows hold 2^LANE_BITS filter bits; the upper index bits pick the row
  localparam int LANE_BITS = (INDEX_BITS > 6) ? 6 : INDEX_BITS - 1;
  localparam int ROW_W     = 1 << LANE_BITS;
  localparam int ADDR_BITS = INDEX_BITS - LANE_BITS;
  localparam int ROWS      = 1 << ADDR_BITS;

  // Probe counter must hold NUM_SUBHASHES itself
  localparam int CNT_BITS = $clog2(NUM_SUBHASHES + 1);

  localparam int HASH_W  = 256;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 32;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } bfq_state_t;

endpackage

// ----- sv/bloom_filter_insert_query_top.sv -----
// Bloom filter with insert, query and clear over a row-organized bit store.
//
// Input channel (in_*): one word per command with a 256-bit hash split in four
// 64-bit words. Result channel (out_*): one word per input word, carrying found
// (queries only) and the insert count after the command. Both channels use
// valid/stall; a word moves when valid is high and stall is low.
//
// Insert and query read the store once per sub-hash through one synchronous
// memory port, one probe per cycle, with inserts writing the modified row back
// the next cycle. An item runs its probes in the run state and its result is
// loaded from the done state; the next item is accepted only back in idle, a
// pace that the single memory port sets. Clear zeroes the store one row per
// cycle (ROWS = 256 rows by default) and then returns its result; unused
// command 3 goes straight to the done state and answers from there.
//
// After reset the block runs the same zeroing pass and holds in_stall
// high until it ends. A stalled result sits in the output register; the next
// item is still accepted and worked on, and only its result waits for the
// register to drain.
`timescale 1ns / 1ps

module bloom_filter_insert_query_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [bfq_pkg::WORD_W-1:0]  in_hash_w0,
  input  logic [bfq_pkg::WORD_W-1:0]  in_hash_w1,
  input  logic [bfq_pkg::WORD_W-1:0]  in_hash_w2,
  input  logic [bfq_pkg::WORD_W-1:0]  in_hash_w3,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [bfq_pkg::COUNT_W-1:0] out_insert_count
);

  bfq_pkg::bfq_state_t state_r, state_nxt;

  logic [bfq_pkg::HASH_W-1:0]    hash_sh_r, hash_sh_nxt;
  logic [1:0]                    cmd_r, cmd_nxt;
  logic [bfq_pkg::CNT_BITS-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [bfq_pkg::ADDR_BITS-1:0] chk_row_r, chk_row_nxt;
  logic [bfq_pkg::LANE_BITS-1:0] chk_lane_r, chk_lane_nxt;
  logic                          found_r, found_nxt;
  logic [bfq_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [bfq_pkg::ADDR_BITS-1:0] sweep_r, sweep_nxt;
  logic                          sweep_reply_r, sweep_reply_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [bfq_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;

  // Last write, kept for read-during-write forwarding
  logic                          fwd_vld_r;
  logic [bfq_pkg::ADDR_BITS-1:0] fwd_row_r;
  logic [bfq_pkg::ROW_W-1:0]     fwd_data_r;

  // Store and its port
  logic [bfq_pkg::ROW_W-1:0]     mem [bfq_pkg::ROWS];
  logic [bfq_pkg::ROW_W-1:0]     rd_data_r;
  logic [bfq_pkg::ADDR_BITS-1:0] mem_raddr;
  logic                          mem_we;
  logic [bfq_pkg::ADDR_BITS-1:0] mem_waddr;
  logic [bfq_pkg::ROW_W-1:0]     mem_wdata;

  logic                          in_accept;
  logic                          out_free;
  logic                          iss_done;
  logic                          sweep_last;
  logic [bfq_pkg::INDEX_BITS-1:0] sub_idx;
  logic [bfq_pkg::ROW_W-1:0]     chk_data;

  assign in_stall   = (state_r != bfq_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign iss_done   = (iss_cnt_r == bfq_pkg::CNT_BITS'(bfq_pkg::NUM_SUBHASHES));
  assign sweep_last = (sweep_r == {bfq_pkg::ADDR_BITS{1'b1}});
  assign sub_idx    = hash_sh_r[bfq_pkg::INDEX_BITS-1:0];

  // Take the row just written when the probe hits it, else the memory data
  assign chk_data = (fwd_vld_r && fwd_row_r == chk_row_r) ? fwd_data_r : rd_data_r;

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_insert_count = out_count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfq_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = sweep_reply_r ? bfq_pkg::ST_DONE : bfq_pkg::ST_IDLE;
        end
      end
      bfq_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_command)
            bfq_pkg::CMD_INSERT, bfq_pkg::CMD_QUERY: state_nxt = bfq_pkg::ST_RUN;
            bfq_pkg::CMD_CLEAR:                      state_nxt = bfq_pkg::ST_SWEEP;
            default:                                 state_nxt = bfq_pkg::ST_DONE;
          endcase
        end
      end
      bfq_pkg::ST_RUN: begin
        if (iss_done) begin
          state_nxt = bfq_pkg::ST_DONE;
        end
      end
      bfq_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bfq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    hash_sh_nxt     = hash_sh_r;
    cmd_nxt         = cmd_r;
    iss_cnt_nxt     = iss_cnt_r;
    chk_vld_nxt     = 1'b0;
    chk_row_nxt     = chk_row_r;
    chk_lane_nxt    = chk_lane_r;
    found_nxt       = found_r;
    count_nxt       = count_r;
    sweep_nxt       = sweep_r;
    sweep_reply_nxt = sweep_reply_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_found_nxt   = out_found_r;
    out_count_nxt   = out_count_r;
    mem_raddr       = sub_idx[bfq_pkg::INDEX_BITS-1:bfq_pkg::LANE_BITS];
    mem_we          = 1'b0;
    mem_waddr       = chk_row_r;
    mem_wdata       = chk_data | (bfq_pkg::ROW_W'(1) << chk_lane_r);

    unique case (state_r)
      bfq_pkg::ST_SWEEP: begin
        // Zero one row per cycle
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
      end
      bfq_pkg::ST_IDLE: begin
        if (in_accept) begin
          hash_sh_nxt = {in_hash_w3, in_hash_w2, in_hash_w1, in_hash_w0};
          cmd_nxt     = in_command;
          iss_cnt_nxt = '0;
          found_nxt   = (in_command == bfq_pkg::CMD_QUERY);
          sweep_nxt   = '0;
          sweep_reply_nxt = 1'b1;
          // Count moves at acceptance; the result picks it up at the end
          if (in_command == bfq_pkg::CMD_INSERT && count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end else if (in_command == bfq_pkg::CMD_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      bfq_pkg::ST_RUN: begin
        // Issue the next probe and advance the hash by one sub-hash
        if (!iss_done) begin
          hash_sh_nxt  = hash_sh_r >> bfq_pkg::INDEX_BITS;
          iss_cnt_nxt  = iss_cnt_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_row_nxt  = sub_idx[bfq_pkg::INDEX_BITS-1:bfq_pkg::LANE_BITS];
          chk_lane_nxt = sub_idx[bfq_pkg::LANE_BITS-1:0];
        end
        // Check the probe read last cycle; inserts write the row back
        if (chk_vld_r) begin
          found_nxt = found_r & chk_data[chk_lane_r];
          mem_we    = (cmd_r == bfq_pkg::CMD_INSERT);
        end
      end
      bfq_pkg::ST_DONE: begin
        // Load the result once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r && (cmd_r == bfq_pkg::CMD_QUERY);
          out_count_nxt = count_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfq_pkg::ST_SWEEP;
      iss_cnt_r     <= '0;
      chk_vld_r     <= 1'b0;
      count_r       <= '0;
      sweep_r       <= '0;
      sweep_reply_r <= 1'b0;
      out_valid_r   <= 1'b0;
      fwd_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      iss_cnt_r     <= iss_cnt_nxt;
      chk_vld_r     <= chk_vld_nxt;
      count_r       <= count_nxt;
      sweep_r       <= sweep_nxt;
      sweep_reply_r <= sweep_reply_nxt;
      out_valid_r   <= out_valid_nxt;
      fwd_vld_r     <= mem_we;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hash_sh_r   <= hash_sh_nxt;
    cmd_r       <= cmd_nxt;
    chk_row_r   <= chk_row_nxt;
    chk_lane_r  <= chk_lane_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
    fwd_row_r   <= mem_waddr;
    fwd_data_r  <= mem_wdata;
  end

  // Bit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // No probe is in flight while the store is being zeroed
  a_sweep_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfq_pkg::ST_SWEEP) |-> !chk_vld_r)
    else $error("probe pending during zeroing pass");

  // Probe counter never runs past the number of sub-hashes
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_cnt_r <= bfq_pkg::CNT_BITS'(bfq_pkg::NUM_SUBHASHES)))
    else $error("probe counter overran");

  // A saturated count holds unless a clear is accepted
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '1 && !(in_accept && in_command == bfq_pkg::CMD_CLEAR)) |=> (count_r == '1))
    else $error("insert count left saturation");

  // A result appears only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == bfq_pkg::ST_DONE))
    else $error("result loaded outside done state");

  // Insert write-back always carries the probed bit set
  a_insert_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == bfq_pkg::ST_RUN) |-> mem_wdata[chk_lane_r])
    else $error("insert write-back lost its bit");

endmodule

// ----- tb/bloom_filter_insert_query_top_tb.sv -----
// Self-checking testbench for the bloom filter insert/query/clear block.
`timescale 1ns / 1ps

module bloom_filter_insert_query_top_tb;

  localparam int         FILTER_BITS    = 1 << bfq_pkg::INDEX_BITS;
  localparam int         PROBE_VEC_W    = bfq_pkg::NUM_SUBHASHES * bfq_pkg::INDEX_BITS;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         RX_HOLD_CYCLES = 300;
  localparam int         QUIET_LIMIT    = 5000;
  localparam int         DRAIN_CYCLES   = 4 * (bfq_pkg::NUM_SUBHASHES + 3);
  localparam int         POOL_MAX       = 48;

  typedef struct packed {
    logic [1:0]                 command;
    logic [bfq_pkg::HASH_W-1:0] hash;
  } bf_cmd_t;

  typedef struct packed {
    logic                        found;
    logic [bfq_pkg::COUNT_W-1:0] count;
  } bf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_command = bfq_pkg::CMD_INSERT;
  logic [bfq_pkg::WORD_W-1:0]  in_hash_w0 = '0;
  logic [bfq_pkg::WORD_W-1:0]  in_hash_w1 = '0;
  logic [bfq_pkg::WORD_W-1:0]  in_hash_w2 = '0;
  logic [bfq_pkg::WORD_W-1:0]  in_hash_w3 = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_found;
  logic [bfq_pkg::COUNT_W-1:0] out_insert_count;

  // Predicted filter contents and insert count
  logic [FILTER_BITS-1:0]      model_bits = '0;
  logic [bfq_pkg::COUNT_W-1:0] model_count = '0;

  bf_cmd_t          cmd_pending[$];
  bf_result_t       expected_results[$];
  logic [PROBE_VEC_W-1:0] probe_pool[$];
  bf_cmd_t          cur_cmd;
  bf_result_t       want;

  int n_queued = 0;
  int n_predicted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic tx_pause = 1'b0;
  int rx_hold_reqs = 0;
  int rx_hold_taken = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  bloom_filter_insert_query_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_hash_w0       (in_hash_w0),
    .in_hash_w1       (in_hash_w1),
    .in_hash_w2       (in_hash_w2),
    .in_hash_w3       (in_hash_w3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_insert_count (out_insert_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sub-hash j of a hash; bits past the top of the hash read as zero
  function automatic logic [bfq_pkg::INDEX_BITS-1:0] probe_index(
      logic [bfq_pkg::HASH_W-1:0] h, int j);
    logic [bfq_pkg::INDEX_BITS-1:0] v;
    int pos;
    v = '0;
    for (int b = 0; b < bfq_pkg::INDEX_BITS; b++) begin
      pos = j * bfq_pkg::INDEX_BITS + b;
      if (pos < bfq_pkg::HASH_W) v[b] = h[pos];
    end
    return v;
  endfunction

  function automatic logic [PROBE_VEC_W-1:0] probes_of(logic [bfq_pkg::HASH_W-1:0] h);
    logic [PROBE_VEC_W-1:0] pv;
    for (int j = 0; j < bfq_pkg::NUM_SUBHASHES; j++)
      pv[j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] = probe_index(h, j);
    return pv;
  endfunction

  // Overlay a set of probe positions on the low bits of a fill pattern
  function automatic logic [bfq_pkg::HASH_W-1:0] with_probes(
      logic [bfq_pkg::HASH_W-1:0] fill, logic [PROBE_VEC_W-1:0] pv);
    for (int pos = 0; pos < PROBE_VEC_W; pos++) begin
      if (pos < bfq_pkg::HASH_W) fill[pos] = pv[pos];
    end
    return fill;
  endfunction

  function automatic logic [bfq_pkg::HASH_W-1:0] rand_hash();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Update the predicted filter with one command and return its result
  function automatic bf_result_t filter_apply(bf_cmd_t c);
    bf_result_t r;
    r.found = 1'b0;
    unique case (c.command)
      bfq_pkg::CMD_INSERT: begin
        for (int j = 0; j < bfq_pkg::NUM_SUBHASHES; j++)
          model_bits[probe_index(c.hash, j)] = 1'b1;
        if (model_count != '1) model_count = model_count + 1'b1;
      end
      bfq_pkg::CMD_QUERY: begin
        r.found = 1'b1;
        for (int j = 0; j < bfq_pkg::NUM_SUBHASHES; j++) begin
          if (!model_bits[probe_index(c.hash, j)]) r.found = 1'b0;
        end
      end
      bfq_pkg::CMD_CLEAR: begin
        model_bits = '0;
        model_count = '0;
      end
      default: ;
    endcase
    r.count = model_count;
    return r;
  endfunction

  // Random command, biased toward queries that revisit inserted positions
  function automatic bf_cmd_t next_random_cmd();
    bf_cmd_t c;
    logic [PROBE_VEC_W-1:0] pv;
    logic [bfq_pkg::INDEX_BITS-1:0] rnd_idx;
    int r;
    int k;
    r = $urandom_range(99);
    c.hash = rand_hash();
    if (r < 2) begin
      c.command = bfq_pkg::CMD_CLEAR;
      probe_pool.delete();
    end else if (r < 4) begin
      c.command = CMD_UNUSED;
    end else if (r < 48) begin
      c.command = bfq_pkg::CMD_INSERT;
      if (probe_pool.size() > 0 && $urandom_range(99) < 40) begin
        // reuse some positions so the filter fills unevenly
        pv = probes_of(c.hash);
        for (int j = 0; j < bfq_pkg::NUM_SUBHASHES; j++) begin
          if ($urandom_range(1) == 0)
            pv[j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] =
              probe_pool[$urandom_range(probe_pool.size() - 1)]
                        [j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS];
        end
        c.hash = with_probes(c.hash, pv);
      end
      probe_pool.push_back(probes_of(c.hash));
      if (probe_pool.size() > POOL_MAX) void'(probe_pool.pop_front());
    end else begin
      c.command = bfq_pkg::CMD_QUERY;
      r = $urandom_range(99);
      if (probe_pool.size() > 0 && r < 70) begin
        pv = probe_pool[$urandom_range(probe_pool.size() - 1)];
        if (r >= 35 && r < 55) begin
          // mix positions from several inserted hashes
          for (int j = 0; j < bfq_pkg::NUM_SUBHASHES; j++)
            pv[j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] =
              probe_pool[$urandom_range(probe_pool.size() - 1)]
                        [j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS];
        end else if (r >= 55) begin
          // knock out one position
          k = $urandom_range(bfq_pkg::NUM_SUBHASHES - 1);
          rnd_idx = bfq_pkg::INDEX_BITS'($urandom());
          pv[k*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] = rnd_idx;
        end
        c.hash = with_probes(c.hash, pv);
      end
    end
    return c;
  endfunction

  task automatic push_cmd(logic [1:0] command, logic [bfq_pkg::HASH_W-1:0] hash);
    bf_cmd_t c;
    c.command = command;
    c.hash = hash;
    cmd_pending.push_back(c);
    n_queued++;
  endtask

  // Queue a batch at the given idle rates and hold until the last word is offered
  task automatic run_phase(int tx_idle, int rx_stall, int n);
    @(negedge clk);
    tx_idle_pct = tx_idle;
    rx_stall_pct = rx_stall;
    for (int i = 0; i < n; i++) begin
      cmd_pending.push_back(next_random_cmd());
      n_queued++;
    end
    while (cmd_pending.size() != 0) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (n_predicted != n_queued || n_checked != n_predicted) @(negedge clk);
  endtask

  // Driver: offer pending words, hold a stalled word, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(filter_apply(cur_cmd));
        n_predicted <= n_predicted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (!tx_pause && cmd_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_cmd = cmd_pending.pop_front();
          in_valid   <= 1'b1;
          in_command <= cur_cmd.command;
          in_hash_w0 <= cur_cmd.hash[63:0];
          in_hash_w1 <= cur_cmd.hash[127:64];
          in_hash_w2 <= cur_cmd.hash[191:128];
          in_hash_w3 <= cur_cmd.hash[255:192];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then pick the next stall value
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (n_checked == n_predicted) begin
          $error("result with nothing expected: found %0b insert_count %0d",
                 out_found, out_insert_count);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked <= n_checked + 1;
          if (out_found !== want.found) begin
            $error("found mismatch: expected %0b, got %0b", want.found, out_found);
            n_errors++;
          end
          if (out_insert_count !== want.count) begin
            $error("insert_count mismatch: expected %0d, got %0d", want.count,
                   out_insert_count);
            n_errors++;
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
        rx_hold_left <= rx_hold_left - 1;
      end else if (rx_hold_taken != rx_hold_reqs) begin
        out_stall <= 1'b1;
        rx_hold_left <= RX_HOLD_CYCLES;
        rx_hold_taken <= rx_hold_taken + 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PROBE_VEC_W-1:0] pv_a;
    logic [PROBE_VEC_W-1:0] pv_b;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty filter, extreme hashes, hits by combination, partial
    // hits, unused command and clear
    pv_a = '0;
    for (int j = 0; j < bfq_pkg::NUM_SUBHASHES; j++)
      pv_a[j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] =
        bfq_pkg::INDEX_BITS'($urandom_range(FILTER_BITS - 2, 1));
    pv_b = '0;
    for (int j = 1; j < bfq_pkg::NUM_SUBHASHES; j += 2)
      pv_b[j*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] = '1;
    push_cmd(bfq_pkg::CMD_QUERY, '0);
    push_cmd(bfq_pkg::CMD_INSERT, '0);
    push_cmd(bfq_pkg::CMD_QUERY, '0);
    push_cmd(bfq_pkg::CMD_QUERY, with_probes('1, '0));
    push_cmd(bfq_pkg::CMD_INSERT, '1);
    push_cmd(bfq_pkg::CMD_QUERY, '1);
    push_cmd(bfq_pkg::CMD_QUERY, with_probes(rand_hash(), pv_b));
    push_cmd(bfq_pkg::CMD_QUERY, rand_hash());
    push_cmd(bfq_pkg::CMD_INSERT, with_probes(rand_hash(), pv_a));
    push_cmd(bfq_pkg::CMD_QUERY, with_probes(rand_hash(), pv_a));
    pv_b = pv_a;
    pv_b[(bfq_pkg::NUM_SUBHASHES-1)*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] =
      ~pv_a[(bfq_pkg::NUM_SUBHASHES-1)*bfq_pkg::INDEX_BITS +: bfq_pkg::INDEX_BITS] ^ 1'b1;
    push_cmd(bfq_pkg::CMD_QUERY, with_probes(rand_hash(), pv_b));
    pv_b = pv_a;
    pv_b[bfq_pkg::INDEX_BITS-1:0] = ~pv_a[bfq_pkg::INDEX_BITS-1:0] ^ 1'b1;
    push_cmd(bfq_pkg::CMD_QUERY, with_probes(rand_hash(), pv_b));
    push_cmd(CMD_UNUSED, rand_hash());
    push_cmd(bfq_pkg::CMD_INSERT, with_probes(rand_hash(), pv_a));
    push_cmd(bfq_pkg::CMD_CLEAR, rand_hash());
    push_cmd(bfq_pkg::CMD_QUERY, '0);
    push_cmd(bfq_pkg::CMD_QUERY, '1);
    push_cmd(bfq_pkg::CMD_QUERY, with_probes('0, pv_a));
    push_cmd(CMD_UNUSED, '1);
    push_cmd(bfq_pkg::CMD_INSERT, '1);
    push_cmd(CMD_UNUSED, '0);
    push_cmd(bfq_pkg::CMD_CLEAR, '1);
    while (cmd_pending.size() != 0) @(negedge clk);

    // Random traffic under the idle/stall mixes
    run_phase(0, 0, 400);
    run_phase(67, 0, 350);
    run_phase(0, 67, 350);
    run_phase(25, 25, 400);

    // Receiver holds off while the sender keeps offering, then sender pauses
    @(negedge clk);
    rx_hold_reqs = rx_hold_reqs + 1;
    run_phase(0, 0, 80);
    tx_pause = 1'b1;
    wait_drained();
    tx_pause = 1'b0;

    run_phase(25, 25, 320);

    // Drain and let any stray results show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
